@@ hw/rtl/named_semaphore_table_core_defines.svh @@
// Assertion macros for the named semaphore table.
// Used by nst_keys and named_semaphore_table_core; expects clk and rst_n in scope.
`ifndef NAMED_SEMAPHORE_TABLE_CORE_DEFINES_SVH
`define NAMED_SEMAPHORE_TABLE_CORE_DEFINES_SVH

// checked on every edge outside reset
`define NST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define NST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/nst_pkg.sv @@
// Shared types and constants for the named semaphore table.
// No dependencies.
`timescale 1ns / 1ps

package nst_pkg;

  localparam int POOL_ENTRIES = 16;
  localparam int COUNT_BITS   = 16;
  localparam int IDX_W        = $clog2(POOL_ENTRIES);

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;

  localparam cnt_t CNT_MAX = '1;

  typedef enum logic [2:0] {
    REQ_OPEN   = 3'd0,
    REQ_WAIT   = 3'd1,
    REQ_POST   = 3'd2,
    REQ_UNLINK = 3'd3,
    REQ_GET    = 3'd4
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MISS   = 2'd1,
    ST_BLOCK  = 2'd2,
    ST_BADIDX = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] name_head;
    logic [23:0] name_tail;
    logic [15:0] init_value;
    logic [3:0]  sem_index;
  } req_t;

  typedef struct packed {
    logic                    hit;
    idx_t                    hit_idx;
    logic                    has_free;
    idx_t                    free_idx;
    logic [POOL_ENTRIES-1:0] in_use;
  } lookup_t;

  typedef struct packed {
    logic        claim;
    logic        drop;
    idx_t        idx;
    logic [63:0] head;
    logic [23:0] tail;
  } key_wr_t;

  typedef struct packed {
    logic en;
    idx_t idx;
    cnt_t val;
  } cnt_wr_t;

  function automatic cnt_t sat_init(input logic [15:0] v);
    if ({16'd0, v} > 32'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return COUNT_BITS'(v);
  endfunction

endpackage

@@ hw/rtl/named_semaphore_table_core.sv @@
// Top level of the named semaphore table: request register, decode, result register.
// Depends on nst_pkg, nst_keys, nst_counts and named_semaphore_table_core_defines.svh.
`timescale 1ns / 1ps
`include "named_semaphore_table_core_defines.svh"
//
// Use:
//   A request is taken at a rising edge where start is high and busy is low;
//   busy is held low, so one request may be given every cycle.
//   in_req_type picks open, wait, post, unlink or get; open and unlink use the
//   11-byte key in_name_head/in_name_tail, wait/post/get use in_sem_index.
//   Each request gives one result word on the out_ ports, marked by out_valid
//   for exactly one cycle once it has passed the request register and then the result register.
//   Throughput is one request per cycle: the key compare over all entries and
//   the count update are combinational between the request register and
//   the result register, so each request sees the state left by the previous.
//   The receiver cannot stall; results are not held.
//   Reset (rst_n low, synchronous) frees every entry and drops any request in
//   flight; keys and counts are only read from entries claimed since.
//
module named_semaphore_table_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [63:0] in_name_head,
  input  logic [23:0] in_name_tail,
  input  logic [15:0] in_init_value,
  input  logic [3:0]  in_sem_index,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [3:0]  out_entry_index,
  output logic [15:0] out_count_out,
  output logic        out_wake,
  output logic        out_created
);
  import nst_pkg::*;

  logic       in_vld_r;
  req_t       in_q_r;
  logic       out_valid_r;
  status_t    out_status_r;
  logic [3:0] out_eidx_r;
  cnt_t       out_count_r;
  logic       out_wake_r;
  logic       out_created_r;

  status_t    status_nxt;
  logic [3:0] eidx_nxt;
  cnt_t       count_nxt;
  logic       wake_nxt;
  logic       created_nxt;

  lookup_t    lk;
  key_wr_t    key_wr;
  cnt_wr_t    cnt_wr;
  idx_t       rd_idx;
  cnt_t       rd_cnt;
  idx_t       req_idx;
  logic       idx_ok;
  req_kind_t  kind;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_q_r <= '{req_type: in_req_type, name_head: in_name_head, name_tail: in_name_tail,
                  init_value: in_init_value, sem_index: in_sem_index};
    end
  end

  nst_keys u_keys (
    .clk       (clk),
    .rst_n     (rst_n),
    .name_head (in_q_r.name_head),
    .name_tail (in_q_r.name_tail),
    .wr        (key_wr),
    .lk        (lk)
  );

  nst_counts u_counts (
    .clk    (clk),
    .rd_idx (rd_idx),
    .rd_cnt (rd_cnt),
    .wr     (cnt_wr)
  );

  assign kind    = req_kind_t'(in_q_r.req_type);
  assign req_idx = IDX_W'(in_q_r.sem_index);
  assign idx_ok  = (32'(in_q_r.sem_index) < POOL_ENTRIES) && lk.in_use[req_idx];
  assign rd_idx  = (kind == REQ_OPEN || kind == REQ_UNLINK) ? lk.hit_idx : req_idx;

  always_comb begin
    status_nxt  = ST_BADIDX;
    eidx_nxt    = in_q_r.sem_index;
    count_nxt   = '0;
    wake_nxt    = 1'b0;
    created_nxt = 1'b0;
    key_wr      = '{claim: 1'b0, drop: 1'b0, idx: lk.free_idx,
                    head: in_q_r.name_head, tail: in_q_r.name_tail};
    cnt_wr      = '{en: 1'b0, idx: rd_idx, val: rd_cnt};
    unique case (kind)
      REQ_OPEN: begin
        if (lk.hit) begin
          status_nxt = ST_OK;
          eidx_nxt   = 4'(lk.hit_idx);
          count_nxt  = rd_cnt;
        end else if (lk.has_free) begin
          key_wr.claim = in_vld_r;
          cnt_wr.en    = in_vld_r;
          cnt_wr.idx   = lk.free_idx;
          cnt_wr.val   = sat_init(in_q_r.init_value);
          status_nxt   = ST_OK;
          eidx_nxt     = 4'(lk.free_idx);
          count_nxt    = sat_init(in_q_r.init_value);
          created_nxt  = 1'b1;
        end else begin
          status_nxt = ST_MISS;
        end
      end
      REQ_UNLINK: begin
        if (lk.hit) begin
          key_wr.drop = in_vld_r;
          key_wr.idx  = lk.hit_idx;
          status_nxt  = ST_OK;
          eidx_nxt    = 4'(lk.hit_idx);
          count_nxt   = rd_cnt;
        end else begin
          status_nxt = ST_MISS;
        end
      end
      REQ_WAIT: begin
        if (idx_ok) begin
          if (rd_cnt == '0) begin
            status_nxt = ST_BLOCK;
          end else begin
            cnt_wr.en  = in_vld_r;
            cnt_wr.val = rd_cnt - cnt_t'(1);
            status_nxt = ST_OK;
            count_nxt  = rd_cnt - cnt_t'(1);
          end
        end
      end
      REQ_POST: begin
        if (idx_ok) begin
          cnt_wr.en  = in_vld_r;
          cnt_wr.val = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + cnt_t'(1);
          status_nxt = ST_OK;
          count_nxt  = cnt_wr.val;
          wake_nxt   = 1'b1;
        end
      end
      REQ_GET: begin
        if (idx_ok) begin
          status_nxt = ST_OK;
          count_nxt  = rd_cnt;
        end
      end
      default: begin
        status_nxt = ST_BADIDX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_status_r  <= status_nxt;
      out_eidx_r    <= eidx_nxt;
      out_count_r   <= count_nxt;
      out_wake_r    <= wake_nxt;
      out_created_r <= created_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_index = out_eidx_r;
  assign out_count_out   = 16'(out_count_r);
  assign out_wake        = out_wake_r;
  assign out_created     = out_created_r;

  `NST_ASSERT(a_valid_follows, out_valid_r |-> $past(in_vld_r), "result word without request")
  `NST_ASSERT(a_created_ok, out_valid_r && out_created_r |-> out_status_r == ST_OK, "bad create status")
  `NST_ASSERT(a_wake_ok, out_valid_r && out_wake_r |-> out_status_r == ST_OK && !out_created_r, "bad wake")
endmodule

@@ hw/rtl/nst_keys.sv @@
// Name key store, in-use bits and parallel name match with free-entry search.
// Depends on nst_pkg and named_semaphore_table_core_defines.svh.
`timescale 1ns / 1ps
`include "named_semaphore_table_core_defines.svh"

module nst_keys (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [63:0]      name_head,
  input  logic [23:0]      name_tail,
  input  nst_pkg::key_wr_t wr,
  output nst_pkg::lookup_t lk
);
  import nst_pkg::*;

  logic [POOL_ENTRIES-1:0] in_use_r;
  logic [POOL_ENTRIES-1:0] in_use_nxt;
  logic [63:0]             head_r [POOL_ENTRIES];
  logic [23:0]             tail_r [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0] match;

  always_comb begin
    lk = '0;
    lk.in_use = in_use_r;
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      match[i] = in_use_r[i] && head_r[i] == name_head && tail_r[i] == name_tail;
    end
    // lowest matching entry wins
    for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        lk.hit     = 1'b1;
        lk.hit_idx = IDX_W'(i);
      end
    end
    // highest free entry wins
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      if (!in_use_r[i]) begin
        lk.has_free = 1'b1;
        lk.free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    in_use_nxt = in_use_r;
    if (wr.claim) begin
      in_use_nxt[wr.idx] = 1'b1;
    end
    if (wr.drop) begin
      in_use_nxt[wr.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
    end else begin
      in_use_r <= in_use_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.claim) begin
      head_r[wr.idx] <= wr.head;
      tail_r[wr.idx] <= wr.tail;
    end
  end

  `NST_ASSERT(a_claim_free, wr.claim |-> !in_use_r[wr.idx], "claim of an entry in use")
  `NST_ASSERT(a_one_write, !(wr.claim && wr.drop), "claim and drop together")
endmodule

@@ hw/rtl/nst_counts.sv @@
// Per-entry count registers, one read address and one write port.
// Depends on nst_pkg.
`timescale 1ns / 1ps

module nst_counts (
  input  logic             clk,
  input  nst_pkg::idx_t    rd_idx,
  output nst_pkg::cnt_t    rd_cnt,
  input  nst_pkg::cnt_wr_t wr
);
  import nst_pkg::*;

  cnt_t cnt_r [POOL_ENTRIES];

  assign rd_cnt = cnt_r[rd_idx];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      cnt_r[wr.idx] <= wr.val;
    end
  end
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for named_semaphore_table_core. A short directed run is followed by
// random open/wait/post/unlink/get traffic, and every result word is checked in order.
// Depends on nst_pkg and the core RTL.

module tb;
  import nst_pkg::*;

  localparam logic [2:0] REQ_BAD_LO = 3'd5;
  localparam logic [2:0] REQ_BAD_HI = 3'd7;
  localparam int RANDOM_REQS = 1200;
  localparam int CALM_TAIL   = 150;
  localparam int NAME_POOL   = 20;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    req_t req;
    bit   drain;
    bit   idle_ok;
  } sem_job_t;

  typedef struct {
    status_t status;
    idx_t    entry;
    cnt_t    count;
    logic    wake;
    logic    created;
  } sem_reply_t;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        start         = 1'b0;
  logic        busy;
  logic [2:0]  in_req_type   = '0;
  logic [63:0] in_name_head  = '0;
  logic [23:0] in_name_tail  = '0;
  logic [15:0] in_init_value = '0;
  logic [3:0]  in_sem_index  = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [3:0]  out_entry_index;
  logic [15:0] out_count_out;
  logic        out_wake;
  logic        out_created;

  sem_job_t   sem_request_q[$];
  sem_reply_t expected_replies[$];
  req_t       cur_req;
  logic       took_word = 1'b0;
  int         gap_left  = 0;
  int         err_count = 0;
  int         cycles    = 0;

  // bench copy of the semaphore pool
  bit          live[POOL_ENTRIES];
  cnt_t        level[POOL_ENTRIES];
  logic [63:0] key_head[POOL_ENTRIES];
  logic [23:0] key_tail[POOL_ENTRIES];

  logic [63:0] pool_head[NAME_POOL];
  logic [23:0] pool_tail[NAME_POOL];
  logic [63:0] dir_head[17];
  logic [23:0] dir_tail[17];

  named_semaphore_table_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_name_head    (in_name_head),
    .in_name_tail    (in_name_tail),
    .in_init_value   (in_init_value),
    .in_sem_index    (in_sem_index),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_count_out   (out_count_out),
    .out_wake        (out_wake),
    .out_created     (out_created)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic sem_reply_t apply_request(input req_t r);
    sem_reply_t rep;
    int i;
    int hit;
    int spare;
    rep.status  = ST_BADIDX;
    rep.entry   = r.sem_index;
    rep.count   = '0;
    rep.wake    = 1'b0;
    rep.created = 1'b0;
    hit   = -1;
    spare = -1;
    for (i = POOL_ENTRIES - 1; i >= 0; i--) begin
      if (live[i] && key_head[i] == r.name_head && key_tail[i] == r.name_tail) hit = i;
    end
    for (i = 0; i < POOL_ENTRIES; i++) begin
      if (!live[i]) spare = i;
    end
    case (r.req_type)
      REQ_OPEN: begin
        if (hit >= 0) begin
          rep.status = ST_OK;
          rep.entry  = idx_t'(hit);
          rep.count  = level[hit];
        end else if (spare < 0) begin
          rep.status = ST_MISS;
        end else begin
          live[spare]     = 1'b1;
          level[spare]    = (r.init_value > CNT_MAX) ? CNT_MAX : cnt_t'(r.init_value);
          key_head[spare] = r.name_head;
          key_tail[spare] = r.name_tail;
          rep.status      = ST_OK;
          rep.entry       = idx_t'(spare);
          rep.count       = level[spare];
          rep.created     = 1'b1;
        end
      end
      REQ_UNLINK: begin
        if (hit >= 0) begin
          live[hit]  = 1'b0;
          rep.status = ST_OK;
          rep.entry  = idx_t'(hit);
          rep.count  = level[hit];
        end else begin
          rep.status = ST_MISS;
        end
      end
      REQ_WAIT, REQ_POST, REQ_GET: begin
        if (live[r.sem_index]) begin
          rep.status = ST_OK;
          if (r.req_type == REQ_WAIT) begin
            if (level[r.sem_index] == '0) begin
              rep.status = ST_BLOCK;
            end else begin
              level[r.sem_index] = level[r.sem_index] - cnt_t'(1);
              rep.count = level[r.sem_index];
            end
          end else if (r.req_type == REQ_POST) begin
            if (level[r.sem_index] != CNT_MAX) begin
              level[r.sem_index] = level[r.sem_index] + cnt_t'(1);
            end
            rep.count = level[r.sem_index];
            rep.wake  = 1'b1;
          end else begin
            rep.count = level[r.sem_index];
          end
        end
      end
      default: begin
      end
    endcase
    return rep;
  endfunction

  task automatic push_req(input logic [2:0] kind, input logic [63:0] head,
                          input logic [23:0] tail, input logic [15:0] init,
                          input logic [3:0] idx, input bit drain, input bit idle_ok);
    sem_job_t job;
    job.req.req_type   = kind;
    job.req.name_head  = head;
    job.req.name_tail  = tail;
    job.req.init_value = init;
    job.req.sem_index  = idx;
    job.drain          = drain;
    job.idle_ok        = idle_ok;
    sem_request_q.push_back(job);
  endtask

  // driver: hold each word until taken, then maybe idle a burst
  always @(negedge clk) begin
    sem_job_t job;
    if (rst_n && !(start && !took_word)) begin
      if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (sem_request_q.size() > 0 &&
                   !(sem_request_q[0].drain && expected_replies.size() > 0)) begin
        job = sem_request_q.pop_front();
        cur_req = job.req;
        in_req_type   <= job.req.req_type;
        in_name_head  <= job.req.name_head;
        in_name_tail  <= job.req.name_tail;
        in_init_value <= job.req.init_value;
        in_sem_index  <= job.req.sem_index;
        start         <= 1'b1;
        if (job.idle_ok && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 10);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check result words, predict on each accepted request
  always @(posedge clk) begin
    sem_reply_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (expected_replies.size() == 0) begin
          err_count = err_count + 1;
          $display("%0t: unexpected word, expected none, got status %0d entry %0d count %0d",
                   $time, out_status, out_entry_index, out_count_out);
        end else begin
          want = expected_replies.pop_front();
          if (out_status !== want.status || out_entry_index !== want.entry ||
              out_count_out !== want.count || out_wake !== want.wake ||
              out_created !== want.created) begin
            err_count = err_count + 1;
            $display("%0t: expected status %0d entry %0d count %0d wake %0d created %0d",
                     $time, want.status, want.entry, want.count, want.wake, want.created);
            $display("%0t:   actual status %0d entry %0d count %0d wake %0d created %0d",
                     $time, out_status, out_entry_index, out_count_out, out_wake,
                     out_created);
          end
        end
      end
      if (start && !busy) expected_replies.push_back(apply_request(cur_req));
      took_word <= start && !busy;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int          i;
    int          k;
    int          b;
    int          pick;
    bit          calm_seg;
    logic [2:0]  kind;
    logic [63:0] head;
    logic [23:0] tail;
    logic [15:0] init;

    for (k = 0; k < NAME_POOL; k++) begin
      if (k < 12) begin
        pool_head[k] = {$urandom, $urandom};
        pool_tail[k] = 24'($urandom);
        if (k % 3 == 0) pool_head[k][63:32] = '0;
        if (k % 2 == 0) pool_tail[k] = '0;
      end else begin
        // near-miss: one key bit away from another pool name
        pool_head[k] = pool_head[k - 12];
        pool_tail[k] = pool_tail[k - 12];
        b = $urandom_range(0, 87);
        if (b < 64) pool_head[k][b] = ~pool_head[k][b];
        else pool_tail[k][b - 64] = ~pool_tail[k][b - 64];
      end
    end

    dir_head[0] = '1;
    dir_tail[0] = '1;
    dir_head[1] = '0;
    dir_tail[1] = '0;
    dir_head[2] = '0;
    dir_tail[2] = 24'd1;
    for (k = 3; k < 17; k++) begin
      dir_head[k] = {$urandom, $urandom};
      dir_tail[k] = 24'($urandom);
    end

    // fill the pool, top entry first
    for (k = 0; k < 16; k++) begin
      if (k == 0) init = '1;
      else if (k == 1) init = '0;
      else if (k == 2) init = 16'd1;
      else init = 16'($urandom);
      push_req(REQ_OPEN, dir_head[k], dir_tail[k], init, 4'($urandom), 1'b0, 1'b1);
    end
    push_req(REQ_OPEN, dir_head[16], dir_tail[16], 16'd7, 4'd0, 1'b0, 1'b1);
    push_req(REQ_OPEN, dir_head[2], dir_tail[2], 16'd9, 4'd0, 1'b0, 1'b1);
    push_req(REQ_WAIT, dir_head[3], dir_tail[3], 16'd0, 4'd14, 1'b0, 1'b1);
    push_req(REQ_POST, dir_head[4], dir_tail[4], 16'd0, 4'd15, 1'b0, 1'b1);
    push_req(REQ_WAIT, dir_head[5], dir_tail[5], 16'd0, 4'd13, 1'b0, 1'b1);
    push_req(REQ_UNLINK, dir_head[1], dir_tail[1], 16'd0, 4'd3, 1'b0, 1'b1);
    push_req(REQ_GET, dir_head[6], dir_tail[6], 16'd0, 4'd14, 1'b0, 1'b1);
    push_req(REQ_UNLINK, dir_head[1], dir_tail[1], 16'd0, 4'd5, 1'b0, 1'b1);
    push_req(REQ_BAD_LO, {$urandom, $urandom}, 24'($urandom), 16'($urandom), 4'd15,
             1'b0, 1'b1);
    push_req(REQ_BAD_HI, dir_head[0], dir_tail[0], 16'hFFFF, 4'd12, 1'b0, 1'b1);

    calm_seg = 1'b0;
    for (i = 0; i < RANDOM_REQS; i++) begin
      if (i % 64 == 0) calm_seg = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 30) kind = REQ_OPEN;
      else if (pick < 48) kind = REQ_WAIT;
      else if (pick < 66) kind = REQ_POST;
      else if (pick < 78) kind = REQ_UNLINK;
      else if (pick < 94) kind = REQ_GET;
      else kind = 3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
      k = $urandom_range(0, NAME_POOL - 1);
      head = pool_head[k];
      tail = pool_tail[k];
      if ($urandom_range(0, 19) == 0) begin
        head = {$urandom, $urandom};
        tail = 24'($urandom);
      end
      case ($urandom_range(0, 5))
        0: init = '0;
        1: init = '1;
        2: init = 16'hFFFE;
        3: init = 16'($urandom_range(1, 3));
        default: init = 16'($urandom);
      endcase
      push_req(kind, head, tail, init, 4'($urandom_range(0, 15)), (i == 400 || i == 800),
               !calm_seg && i < RANDOM_REQS - CALM_TAIL);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (sem_request_q.size() != 0 || start || expected_replies.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);

    if (err_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
